[hdl/psk_pkg.sv]
// ----------------------------------------------------------------------------
// psk_pkg
// Shared constants for the planar six-joint kinematics core: fixed-point
// formats of the sine/cosine series engine and its Horner coefficients.
// ----------------------------------------------------------------------------
package psk_pkg;

	// series engine word: unsigned Q2.46
	localparam int MW   = 48;
	localparam int FRAC = 46;
	localparam logic [MW-1:0] ONE     = 48'h4000_0000_0000;
	localparam logic [MW-1:0] HALF_PI = 48'h6487_ED51_10B4;

	// Horner steps for sine and cosine
	localparam int SERIES_K = 10;

	// 1 / ((2k)(2k+1)) for the sine series
	localparam logic [MW-1:0] SIN_C [1:SERIES_K] = '{
		ONE / (2 * 3),   ONE / (4 * 5),   ONE / (6 * 7),   ONE / (8 * 9),
		ONE / (10 * 11), ONE / (12 * 13), ONE / (14 * 15), ONE / (16 * 17),
		ONE / (18 * 19), ONE / (20 * 21)
	};

	// 1 / ((2k-1)(2k)) for the cosine series
	localparam logic [MW-1:0] COS_C [1:SERIES_K] = '{
		ONE / (1 * 2),   ONE / (3 * 4),   ONE / (5 * 6),   ONE / (7 * 8),
		ONE / (9 * 10),  ONE / (11 * 12), ONE / (13 * 14), ONE / (15 * 16),
		ONE / (17 * 18), ONE / (19 * 20)
	};

	// link and result formats
	localparam int NUM_JOINTS = 6;
	localparam int LEN_W      = 16;
	localparam int POS_W      = 20;
	localparam int IDX_W      = 3;
	localparam logic [IDX_W-1:0] LAST_JOINT = 3'd5;
	localparam logic [LEN_W-1:0] LEN_RESET  = 16'd4096;

endpackage

[hdl/planar_six_joint_kinematics_core.sv]
// ----------------------------------------------------------------------------
// planar_six_joint_kinematics_core
// Forward kinematics and Jacobian columns of a planar six-link arm. Each item
// of six joint angles yields six results, one per link end.
// ----------------------------------------------------------------------------
// Flow: each joint angle of an item passes the sequencer, the series pipeline,
//   T1, T2 and T3 into a result bank; a new item enters on the last joint issue.
// Throughput: one result per cycle unless out_stall holds it; the single shared
//   series pipeline takes one joint angle per cycle, also stalled by out_stall.
// Reset: arst_n clears all control state and sets every link length to 1.0.
module planar_six_joint_kinematics_core #(
	parameter int ANGLE_BITS     = 16,
	parameter int TRIG_FRAC_BITS = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [ANGLE_BITS-1:0]                angle_one,
	input  logic [ANGLE_BITS-1:0]                angle_two,
	input  logic [ANGLE_BITS-1:0]                angle_three,
	input  logic [ANGLE_BITS-1:0]                angle_four,
	input  logic [ANGLE_BITS-1:0]                angle_five,
	input  logic [ANGLE_BITS-1:0]                angle_six,
	// result output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [psk_pkg::IDX_W-1:0]            joint_index,
	output logic signed [psk_pkg::POS_W-1:0]     pos_x,
	output logic signed [psk_pkg::POS_W-1:0]     pos_y,
	output logic [ANGLE_BITS-1:0]                heading,
	output logic signed [psk_pkg::POS_W-1:0]     jac_x,
	output logic signed [psk_pkg::POS_W-1:0]     jac_y,
	output logic                                 last,
	// configuration
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [psk_pkg::IDX_W-1:0]            cfg_index,
	input  logic [psk_pkg::LEN_W-1:0]            cfg_data
);

	localparam int MW     = psk_pkg::MW;
	localparam int FRAC   = psk_pkg::FRAC;
	localparam int K      = psk_pkg::SERIES_K;
	localparam int NJ     = psk_pkg::NUM_JOINTS;
	localparam int POS_W  = psk_pkg::POS_W;
	localparam int IDX_W  = psk_pkg::IDX_W;
	localparam int LEN_W  = psk_pkg::LEN_W;
	localparam int TF     = TRIG_FRAC_BITS;
	localparam int MAG_W  = TF + 1;
	localparam int TRIG_W = TF + 2;
	localparam int PROD_W = LEN_W + 1 + TRIG_W;
	localparam int LAT    = 6 + 4 * K;
	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (TF - 1);

	typedef struct packed {
		logic                  vld;
		logic [IDX_W-1:0]      idx;
		logic [ANGLE_BITS-1:0] head;
	} sb_t;

	logic adv;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [LEN_W-1:0] len_q [0:NJ-1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NJ; i++) len_q[i] <= psk_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			for (int i = 0; i < NJ; i++) begin
				if (cfg_index == IDX_W'(i)) len_q[i] <= cfg_data;
			end
		end
	end

	// ------------------------------------------------------------------
	// input sequencer: one joint per cycle, held by out_stall, into the series pipeline
	// ------------------------------------------------------------------
	logic [ANGLE_BITS-1:0] ang_q [0:NJ-1];
	logic                  busy_q;
	logic [IDX_W-1:0]      idx_q;
	logic [ANGLE_BITS-1:0] head_q;
	logic                  in_acc;
	logic                  issue;
	logic [ANGLE_BITS-1:0] nxt_head;
	sb_t                   sb_pipe [0:LAT];

	assign in_stall = busy_q && !(adv && idx_q == psk_pkg::LAST_JOINT);
	assign in_acc   = in_valid && !in_stall;
	assign issue    = busy_q && adv;
	assign nxt_head = head_q + ang_q[idx_q];

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ang_q[0] <= angle_one;
			ang_q[1] <= angle_two;
			ang_q[2] <= angle_three;
			ang_q[3] <= angle_four;
			ang_q[4] <= angle_five;
			ang_q[5] <= angle_six;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			idx_q      <= '0;
			head_q     <= '0;
		end else begin
			if (issue) begin
				if (idx_q == psk_pkg::LAST_JOINT) begin
					busy_q <= in_acc;
					idx_q  <= '0;
					head_q <= '0;
				end else begin
					idx_q  <= idx_q + 1'b1;
					head_q <= nxt_head;
				end
			end else if (in_acc) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				head_q <= '0;
			end
		end
	end

	// sideband follows the series pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LAT; i++) sb_pipe[i] <= '0;
		end else if (adv) begin
			sb_pipe[0].vld  <= issue;
			sb_pipe[0].idx  <= idx_q;
			sb_pipe[0].head <= nxt_head;
			for (int i = 1; i <= LAT; i++) sb_pipe[i] <= sb_pipe[i-1];
		end
	end

	// ------------------------------------------------------------------
	// series pipeline: reduced angle to radians, then x squared
	// ------------------------------------------------------------------
	logic [MW-1:0]   r_ext;
	logic [2*MW-1:0] p_rad, p_sq;
	logic [MW-1:0]   x_rad;
	logic [MW-1:0]   x_s1, x_s2;

	assign r_ext = MW'(sb_pipe[0].head[ANGLE_BITS-3:0]);

	psk_mul u_mul_rad (.clk(clk), .en(adv), .a(r_ext), .b(psk_pkg::HALF_PI), .p(p_rad));

	assign x_rad = p_rad[ANGLE_BITS-2 +: MW];

	psk_mul u_mul_sq (.clk(clk), .en(adv), .a(x_rad), .b(x_rad), .p(p_sq));

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x_rad;
			x_s2 <= x_s1;
		end
	end

	// ------------------------------------------------------------------
	// Horner steps, highest order first
	// ------------------------------------------------------------------
	logic [MW-1:0] st_x2 [0:K];
	logic [MW-1:0] st_x  [0:K];
	logic [MW-1:0] st_ts [0:K];
	logic [MW-1:0] st_tc [0:K];

	assign st_x2[0] = p_sq[FRAC +: MW];
	assign st_x[0]  = x_s2;
	assign st_ts[0] = psk_pkg::ONE;
	assign st_tc[0] = psk_pkg::ONE;

	for (genvar i = 0; i < K; i++) begin : g_step
		localparam int KT = K - i;
		logic [2*MW-1:0] pa_s, pa_c, pb_s, pb_c;
		logic [MW-1:0]   qs, qc, ds, dc;
		logic [MW-1:0]   x2_s1, x2_s2, x2_s3, x2_s4;
		logic [MW-1:0]   xv_s1, xv_s2, xv_s3, xv_s4;

		psk_mul u_mul_as (.clk(clk), .en(adv), .a(st_x2[i]), .b(st_ts[i]), .p(pa_s));
		psk_mul u_mul_ac (.clk(clk), .en(adv), .a(st_x2[i]), .b(st_tc[i]), .p(pa_c));

		assign qs = pa_s[FRAC +: MW];
		assign qc = pa_c[FRAC +: MW];

		psk_mul u_mul_bs (.clk(clk), .en(adv), .a(qs), .b(psk_pkg::SIN_C[KT]), .p(pb_s));
		psk_mul u_mul_bc (.clk(clk), .en(adv), .a(qc), .b(psk_pkg::COS_C[KT]), .p(pb_c));

		assign ds = pb_s[FRAC +: MW];
		assign dc = pb_c[FRAC +: MW];

		// 1 - d, floored at zero
		assign st_ts[i+1] = (ds > psk_pkg::ONE) ? '0 : psk_pkg::ONE - ds;
		assign st_tc[i+1] = (dc > psk_pkg::ONE) ? '0 : psk_pkg::ONE - dc;

		always_ff @(posedge clk) begin
			if (adv) begin
				x2_s1 <= st_x2[i];
				x2_s2 <= x2_s1;
				x2_s3 <= x2_s2;
				x2_s4 <= x2_s3;
				xv_s1 <= st_x[i];
				xv_s2 <= xv_s1;
				xv_s3 <= xv_s2;
				xv_s4 <= xv_s3;
			end
		end

		assign st_x2[i+1] = x2_s4;
		assign st_x[i+1]  = xv_s4;
	end

	// sine = x * series; cosine waits alongside
	logic [2*MW-1:0] p_sin;
	logic [MW-1:0]   tc_s1, tc_s2;
	logic [MW-1:0]   sin_raw;

	psk_mul u_mul_sin (.clk(clk), .en(adv), .a(st_x[K]), .b(st_ts[K]), .p(p_sin));

	always_ff @(posedge clk) begin
		if (adv) begin
			tc_s1 <= st_tc[K];
			tc_s2 <= tc_s1;
		end
	end

	assign sin_raw = p_sin[FRAC +: MW];

	// ------------------------------------------------------------------
	// T1: scale by 2^TF - 1, round, fold quadrant
	// ------------------------------------------------------------------
	logic [MW+TF-1:0]        sp_s, sp_c;
	logic [TF+2:0]           sr_s, sr_c;
	logic [MAG_W-1:0]        mag_s, mag_c;
	logic signed [TRIG_W-1:0] ps, pc;
	logic signed [TRIG_W-1:0] trig_s_t1, trig_c_t1;
	sb_t                     sb_t1;

	always_comb begin
		sp_s  = {sin_raw, {TF{1'b0}}} - (MW+TF)'(sin_raw);
		sp_c  = {tc_s2, {TF{1'b0}}} - (MW+TF)'(tc_s2);
		sr_s  = sp_s[MW+TF-1:FRAC-1] + 1'b1;
		sr_c  = sp_c[MW+TF-1:FRAC-1] + 1'b1;
		mag_s = sr_s[MAG_W:1];
		mag_c = sr_c[MAG_W:1];
		ps    = signed'({1'b0, mag_s});
		pc    = signed'({1'b0, mag_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_t1 <= '0;
		end else if (adv) begin
			sb_t1 <= sb_pipe[LAT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (sb_pipe[LAT].head[ANGLE_BITS-1:ANGLE_BITS-2])
				2'd0: begin
					trig_s_t1 <= ps;
					trig_c_t1 <= pc;
				end
				2'd1: begin
					trig_s_t1 <= pc;
					trig_c_t1 <= -ps;
				end
				2'd2: begin
					trig_s_t1 <= -ps;
					trig_c_t1 <= -pc;
				end
				default: begin
					trig_s_t1 <= -pc;
					trig_c_t1 <= ps;
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// T2: link length times cosine and sine
	// ------------------------------------------------------------------
	logic signed [PROD_W-1:0] prod_x_t2, prod_y_t2;
	logic signed [LEN_W:0]    len_sx;
	sb_t                      sb_t2;

	assign len_sx = signed'({1'b0, len_q[sb_t1.idx]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sb_t2 <= '0;
		end else if (adv) begin
			sb_t2 <= sb_t1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_t2 <= len_sx * trig_c_t1;
			prod_y_t2 <= len_sx * trig_s_t1;
		end
	end

	// ------------------------------------------------------------------
	// T3: round to Q.12, accumulate positions, write result bank
	// ------------------------------------------------------------------
	logic signed [PROD_W-1:0] rx, ry;
	logic signed [POS_W-1:0]  dx, dy;
	logic signed [POS_W-1:0]  acc_x_q, acc_y_q;
	logic signed [POS_W-1:0]  st_px, st_py;
	logic                     wr_en;

	logic signed [POS_W-1:0]  bk_px_q  [0:1][0:NJ-1];
	logic signed [POS_W-1:0]  bk_py_q  [0:1][0:NJ-1];
	logic signed [POS_W-1:0]  bk_sx_q  [0:1][0:NJ-1];
	logic signed [POS_W-1:0]  bk_sy_q  [0:1][0:NJ-1];
	logic [ANGLE_BITS-1:0]    bk_hd_q  [0:1][0:NJ-1];
	logic signed [POS_W-1:0]  tip_x_q  [0:1];
	logic signed [POS_W-1:0]  tip_y_q  [0:1];
	logic [1:0]               full_q;
	logic                     wr_bank_q;
	logic                     rd_bank_q;
	logic [IDX_W-1:0]         rd_idx_q;
	logic                     emit;

	always_comb begin
		rx    = prod_x_t2 + RND_HALF;
		ry    = prod_y_t2 + RND_HALF;
		dx    = POS_W'(rx >>> TF);
		dy    = POS_W'(ry >>> TF);
		st_px = (sb_t2.idx == '0) ? '0 : acc_x_q;
		st_py = (sb_t2.idx == '0) ? '0 : acc_y_q;
	end

	assign wr_en = adv && sb_t2.vld;
	assign emit  = adv && full_q[rd_bank_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			acc_x_q <= st_px + dx;
			acc_y_q <= st_py + dy;
			bk_px_q[wr_bank_q][sb_t2.idx] <= st_px + dx;
			bk_py_q[wr_bank_q][sb_t2.idx] <= st_py + dy;
			bk_sx_q[wr_bank_q][sb_t2.idx] <= st_px;
			bk_sy_q[wr_bank_q][sb_t2.idx] <= st_py;
			bk_hd_q[wr_bank_q][sb_t2.idx] <= sb_t2.head;
			if (sb_t2.idx == psk_pkg::LAST_JOINT) begin
				tip_x_q[wr_bank_q] <= st_px + dx;
				tip_y_q[wr_bank_q] <= st_py + dy;
			end
		end
	end

	// bank control: writer fills one bank while the reader drains the other
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= '0;
			wr_bank_q <= 1'b0;
			rd_bank_q <= 1'b0;
			rd_idx_q  <= '0;
		end else begin
			if (wr_en && sb_t2.idx == psk_pkg::LAST_JOINT) begin
				full_q[wr_bank_q] <= 1'b1;
				wr_bank_q         <= !wr_bank_q;
			end
			if (emit) begin
				if (rd_idx_q == psk_pkg::LAST_JOINT) begin
					full_q[rd_bank_q] <= 1'b0;
					rd_bank_q         <= !rd_bank_q;
					rd_idx_q          <= '0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	logic out_valid_q;

	assign adv       = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			joint_index <= rd_idx_q;
			pos_x       <= bk_px_q[rd_bank_q][rd_idx_q];
			pos_y       <= bk_py_q[rd_bank_q][rd_idx_q];
			heading     <= bk_hd_q[rd_bank_q][rd_idx_q];
			jac_x       <= bk_sy_q[rd_bank_q][rd_idx_q] - tip_y_q[rd_bank_q];
			jac_y       <= tip_x_q[rd_bank_q] - bk_sx_q[rd_bank_q][rd_idx_q];
			last        <= (rd_idx_q == psk_pkg::LAST_JOINT);
		end
	end

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// a new item only enters on the last issue cycle of the previous one
	a_accept_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && busy_q |-> idx_q == psk_pkg::LAST_JOINT && adv)
		else $error("item accepted while sequencer mid-item");

	// the writer never overruns a bank the reader has not drained
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full_q[wr_bank_q])
		else $error("result bank overwritten before drained");

	// results of one item come out in joint order, with no gap
	a_joint_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && joint_index != psk_pkg::LAST_JOINT
		|=> out_valid && joint_index == $past(joint_index) + 1'b1)
		else $error("joint order broken");

endmodule

[hdl/psk_mul.sv]
// ----------------------------------------------------------------------------
// psk_mul
// Two-stage unsigned multiplier for the series engine word: four half-width
// partial products in the first stage, their sum in the second.
// ----------------------------------------------------------------------------
module psk_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [psk_pkg::MW-1:0]      a,
	input  logic [psk_pkg::MW-1:0]      b,
	output logic [2*psk_pkg::MW-1:0]    p
);

	localparam int H  = psk_pkg::MW / 2;
	localparam int PW = 2 * psk_pkg::MW;

	logic [2*H-1:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [PW-1:0]  p_s2;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[H-1:0] * b[H-1:0];
			lh_s1 <= a[H-1:0] * b[2*H-1:H];
			hl_s1 <= a[2*H-1:H] * b[H-1:0];
			hh_s1 <= a[2*H-1:H] * b[2*H-1:H];
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= {hh_s1, ll_s1} + (PW'(lh_s1) << H) + (PW'(hl_s1) << H);
		end
	end

	assign p = p_s2;

endmodule
